@@ rtl/ceq_pkg.sv @@
// Package for the coalescing expiring event queue: depth, entry type, codes.
// Used by ceq_cell and coalescing_expiring_event_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ceq_pkg;
	localparam int QueueDepth = 8;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_POP     = 2'd1;
	localparam logic [1:0] ACT_DISMISS = 2'd2;
	localparam logic [1:0] ACT_TICK    = 2'd3;

	localparam logic [2:0] ST_APPENDED  = 3'd0;
	localparam logic [2:0] ST_COALESCED = 3'd1;
	localparam logic [2:0] ST_REMOVED   = 3'd2;
	localparam logic [2:0] ST_NOTHING   = 3'd3;
	localparam logic [2:0] ST_TICKED    = 3'd4;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_TTL    = 2'd1;
	localparam logic [1:0] REG_TIER   = 2'd2;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  tier;
		logic [31:0] sender;
		logic [7:0]  conv;
		logic [15:0] msg;
		logic [31:0] time_ms;
		logic [31:0] deadline;
	} entry_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic              shift;    // cells at or above sel take their neighbor's entry
		logic              load;     // cell ld_idx takes the new entry
		logic              refresh;  // refresh the cell selected by sel
		logic [IdxW-1:0]   sel;
		logic [IdxW-1:0]   ld_idx;
		logic [31:0]       now_ms;
		logic [15:0]       msg;
		logic [31:0]       deadline;
	} cell_cmd_t;
endpackage
`default_nettype wire

@@ rtl/ceq_cell.sv @@
// One storage cell of the queue row: holds an entry, passes it to its neighbor.
// Depends on ceq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ceq_cell
	import ceq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [IdxW-1:0]  my_idx,
	input  wire cell_cmd_t        cmd,
	input  wire entry_t           from_next,
	input  wire entry_t           new_entry,
	output entry_t                ent
);
	entry_t ent_q;
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.load && cmd.ld_idx == my_idx) begin
			ent_q <= new_entry;
		end else if (cmd.shift && my_idx >= cmd.sel) begin
			ent_q <= from_next;
		end else if (cmd.refresh && cmd.sel == my_idx) begin
			ent_q.time_ms  <= cmd.now_ms;
			ent_q.msg      <= cmd.msg;
			ent_q.deadline <= cmd.deadline;
		end
	end
endmodule
`default_nettype wire

@@ rtl/coalescing_expiring_event_queue.sv @@
// Coalescing expiring event queue: a row of ceq_cell entries that shifts
// toward the head. Depends on ceq_pkg and ceq_cell.
// A push scans the occupied entries in S_SCAN before S_APPLY, a tick walks them in S_TICK,
// and a pop or dismiss goes straight to S_APPLY; each result is then held in S_OUT.
// One transaction is worked at a time; the next is taken once the result has been accepted.
// Reset empties the queue and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module coalescing_expiring_event_queue
	import ceq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [30:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  kind,
	input  wire logic [1:0]  tier,
	input  wire logic [31:0] node_id,
	input  wire logic [7:0]  conversation,
	input  wire logic [15:0] message_ref,
	input  wire logic [31:0] now_ms,
	input  wire logic [2:0]  slot,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [3:0]       occupancy,
	output logic [3:0]       expired_count,
	output logic             head_valid,
	output logic [3:0]       head_kind,
	output logic [1:0]       head_tier,
	output logic [31:0]      head_node_id,
	output logic [7:0]       head_conversation,
	output logic [15:0]      head_message_ref,
	output logic [31:0]      head_time_ms,
	output logic [31:0]      head_expiry_ms
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TICK, S_APPLY, S_OUT} state_t;

	state_t            state_q;
	logic [30:0]       window_q, ttl_q;
	logic [1:0]        btier_q;
	logic [CntW-1:0]   count_q, idx_q;
	logic [3:0]        expired_q;
	logic [1:0]        act_q;
	entry_t            in_q;
	logic [IdxW-1:0]   slot_q, best_q;
	logic [31:0]       best_time_q;
	logic              found_q;
	logic [2:0]        status_q;

	entry_t            ent [QueueDepth];
	entry_t            nxt [QueueDepth];
	cell_cmd_t         cmd;

	entry_t            probe, head;
	logic              in_use, match, newer, expd, merge, full, slot_ok;
	logic [31:0]       age, tdiff, ddiff;

	assign probe   = ent[idx_q[IdxW-1:0]];
	assign in_use  = idx_q < count_q;
	assign match   = probe.kind == in_q.kind && probe.sender == in_q.sender &&
		probe.conv == in_q.conv;
	assign tdiff   = probe.time_ms - best_time_q;
	assign newer   = !found_q || (!tdiff[31] && tdiff != 32'd0);
	assign ddiff   = in_q.time_ms - probe.deadline;
	assign expd    = probe.deadline != 32'd0 && !ddiff[31];
	assign age     = in_q.time_ms - best_time_q;
	assign merge   = found_q && ($signed(age) <= $signed({1'b0, window_q}));
	assign full    = count_q == CntW'(QueueDepth);
	assign slot_ok = CntW'(slot_q) < count_q;

	always_comb begin
		cmd = '0;
		cmd.now_ms   = in_q.time_ms;
		cmd.msg      = in_q.msg;
		cmd.deadline = in_q.deadline;
		cmd.ld_idx   = full ? IdxW'(QueueDepth - 1) : count_q[IdxW-1:0];
		case (state_q)
			S_TICK: begin
				if (in_use && expd) begin
					cmd.shift = 1'b1;
					cmd.sel   = idx_q[IdxW-1:0];
				end
			end
			S_APPLY: begin
				case (act_q)
					ACT_PUSH: begin
						if (merge) begin
							cmd.refresh = 1'b1;
							cmd.sel     = best_q;
						end else begin
							cmd.load  = 1'b1;
							cmd.shift = full;
						end
					end
					ACT_POP: cmd.shift = count_q != '0;
					ACT_DISMISS: begin
						if (slot_ok) begin
							cmd.shift = 1'b1;
							cmd.sel   = slot_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < QueueDepth; g++) begin : g_cells
		if (g < QueueDepth - 1) begin : g_link
			assign nxt[g] = ent[g + 1];
		end else begin : g_end
			assign nxt[g] = ent[g];
		end
		ceq_cell u_cell (
			.clk       (clk),
			.my_idx    (IdxW'(g)),
			.cmd       (cmd),
			.from_next (nxt[g]),
			.new_entry (in_q),
			.ent       (ent[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= 31'd2000;
			ttl_q       <= 31'd5000;
			btier_q     <= 2'd1;
			count_q     <= '0;
			out_valid   <= 1'b0;
			idx_q       <= '0;
			expired_q   <= '0;
			found_q     <= 1'b0;
			act_q       <= ACT_PUSH;
			in_q        <= '0;
			slot_q      <= '0;
			best_q      <= '0;
			best_time_q <= '0;
			status_q    <= ST_APPENDED;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_WINDOW: window_q <= cfg_data;
					REG_TTL:    ttl_q    <= cfg_data;
					REG_TIER:   btier_q  <= cfg_data[1:0];
					default:    ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						in_q.kind    <= kind;
						in_q.tier    <= tier;
						in_q.sender  <= node_id;
						in_q.conv    <= conversation;
						in_q.msg     <= message_ref;
						in_q.time_ms <= now_ms;
						in_q.deadline <= (tier == btier_q) ? now_ms + {1'b0, ttl_q} : 32'd0;
						slot_q  <= slot;
						idx_q   <= '0;
						expired_q <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						best_time_q <= '0;
						case (action)
							ACT_PUSH: state_q <= S_SCAN;
							ACT_TICK: state_q <= S_TICK;
							default:  state_q <= S_APPLY;
						endcase
					end
				end
				S_SCAN: begin
					if (in_use) begin
						if (match && newer) begin
							found_q     <= 1'b1;
							best_q      <= idx_q[IdxW-1:0];
							best_time_q <= probe.time_ms;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_TICK: begin
					if (in_use) begin
						if (expd) begin
							count_q   <= count_q - 1'b1;
							expired_q <= expired_q + 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						status_q  <= ST_TICKED;
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_APPLY: begin
					case (act_q)
						ACT_PUSH: begin
							if (merge) begin
								status_q <= ST_COALESCED;
							end else begin
								status_q <= ST_APPENDED;
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
						end
						ACT_POP: begin
							if (count_q != '0) begin
								status_q <= ST_REMOVED;
								count_q  <= count_q - 1'b1;
							end else begin
								status_q <= ST_NOTHING;
							end
						end
						ACT_DISMISS: begin
							if (slot_ok) begin
								status_q <= ST_REMOVED;
								count_q  <= count_q - 1'b1;
							end else begin
								status_q <= ST_NOTHING;
							end
						end
						default: status_q <= ST_NOTHING;
					endcase
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				default: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign status = status_q;
	assign occupancy = 4'(count_q);
	assign expired_count = expired_q;
	assign head_valid = count_q != '0;
	assign head = head_valid ? ent[0] : '0;
	assign head_kind = head.kind;
	assign head_tier = head.tier;
	assign head_node_id = head.sender;
	assign head_conversation = head.conv;
	assign head_message_ref = head.msg;
	assign head_time_ms = head.time_ms;
	assign head_expiry_ms = head.deadline;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy));
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid);
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid == (occupancy != 4'd0));
	a_expired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> expired_count <= 4'(QueueDepth));
`endif
endmodule
`default_nettype wire

@@ tb/tb_coalescing_expiring_event_queue.sv @@
// Self-checking testbench for the coalescing expiring event queue.
// Depends on ceq_pkg and coalescing_expiring_event_queue; drives random and directed actions.
`timescale 1ns / 1ps
module tb_coalescing_expiring_event_queue;
	import ceq_pkg::*;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  kind;
		logic [1:0]  tier;
		logic [31:0] node_id;
		logic [7:0]  conversation;
		logic [15:0] message_ref;
		logic [31:0] now_ms;
		logic [2:0]  slot;
	} event_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  occupancy;
		logic [3:0]  expired_count;
		logic        head_valid;
		entry_t      head;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	event_t cur = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [3:0] occupancy, expired_count, head_kind;
	logic head_valid;
	logic [1:0] head_tier;
	logic [31:0] head_node_id, head_time_ms, head_expiry_ms;
	logic [7:0] head_conversation;
	logic [15:0] head_message_ref;

	coalescing_expiring_event_queue uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(cur.action), .kind(cur.kind),
		.tier(cur.tier), .node_id(cur.node_id), .conversation(cur.conversation),
		.message_ref(cur.message_ref), .now_ms(cur.now_ms), .slot(cur.slot),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.occupancy(occupancy), .expired_count(expired_count), .head_valid(head_valid),
		.head_kind(head_kind), .head_tier(head_tier), .head_node_id(head_node_id),
		.head_conversation(head_conversation), .head_message_ref(head_message_ref),
		.head_time_ms(head_time_ms), .head_expiry_ms(head_expiry_ms)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	event_t pending_events[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	int idle_cnt = 0;
	int out_wait = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;

	logic [30:0] window_ms, ttl_ms;
	logic [1:0] banner_code;
	entry_t row[QueueDepth];
	int held;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] ms_diff(logic [31:0] a, logic [31:0] b);
		return a - b;
	endfunction

	function automatic void remove_entry(int pos);
		for (int i = pos; i + 1 < held; i++) row[i] = row[i + 1];
		held--;
	endfunction

	function automatic outcome_t queue_apply(event_t ev);
		outcome_t o;
		int best;
		logic [31:0] expiry;
		int k;
		o = '0;
		best = -1;
		expiry = (ev.tier == banner_code) ? ev.now_ms + {1'b0, ttl_ms} : 32'd0;
		case (ev.action)
			ACT_PUSH: begin
				for (int i = 0; i < held; i++)
					if (row[i].kind == ev.kind && row[i].sender == ev.node_id &&
					    row[i].conv == ev.conversation)
						if (best < 0 || ms_diff(row[i].time_ms, row[best].time_ms) > 0)
							best = i;
				if (best >= 0 && ms_diff(ev.now_ms, row[best].time_ms) <=
				    $signed({1'b0, window_ms})) begin
					row[best].time_ms = ev.now_ms;
					row[best].deadline = expiry;
					row[best].msg = ev.message_ref;
					o.status = ST_COALESCED;
				end else begin
					if (held >= QueueDepth) remove_entry(0);
					row[held] = '{ev.kind, ev.tier, ev.node_id, ev.conversation,
						ev.message_ref, ev.now_ms, expiry};
					held++;
					o.status = ST_APPENDED;
				end
			end
			ACT_POP: begin
				if (held == 0) o.status = ST_NOTHING;
				else begin
					remove_entry(0);
					o.status = ST_REMOVED;
				end
			end
			ACT_DISMISS: begin
				if (ev.slot >= held) o.status = ST_NOTHING;
				else begin
					remove_entry(ev.slot);
					o.status = ST_REMOVED;
				end
			end
			default: begin
				k = 0;
				while (k < held) begin
					if (row[k].deadline != 0 && ms_diff(ev.now_ms, row[k].deadline) >= 0) begin
						remove_entry(k);
						o.expired_count++;
					end else k++;
				end
				o.status = ST_TICKED;
			end
		endcase
		o.occupancy = 4'(held);
		o.head_valid = held > 0;
		if (held > 0) o.head = row[0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
	end

	// Driver: one transaction at a time, with random gaps between them.
	always @(negedge clk) begin
		event_t ev;
		if (arst_n && (!in_valid || in_taken)) begin
			if (idle_cnt > 0) begin
				idle_cnt <= idle_cnt - 1;
				in_valid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				ev = pending_events.pop_front();
				expected_outcomes.push_back(queue_apply(ev));
				cur <= ev;
				in_valid <= 1'b1;
				idle_cnt <= gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int w;
		w = out_taken ? gap_len() : out_wait;
		if (w > 0) begin
			out_ready <= 1'b0;
			out_wait <= w - 1;
		end else begin
			out_ready <= 1'b1;
			out_wait <= 0;
		end
	end

	always @(posedge clk) begin
		outcome_t w;
		if (out_valid && out_ready) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected result", status, 0);
			end else begin
				w = expected_outcomes.pop_front();
				if (status !== w.status) report_mismatch("status", status, w.status);
				if (occupancy !== w.occupancy)
					report_mismatch("occupancy", occupancy, w.occupancy);
				if (expired_count !== w.expired_count)
					report_mismatch("expired_count", expired_count, w.expired_count);
				if (head_valid !== w.head_valid)
					report_mismatch("head_valid", head_valid, w.head_valid);
				if (head_kind !== w.head.kind) report_mismatch("head_kind", head_kind, w.head.kind);
				if (head_tier !== w.head.tier) report_mismatch("head_tier", head_tier, w.head.tier);
				if (head_node_id !== w.head.sender)
					report_mismatch("head_node_id", head_node_id, w.head.sender);
				if (head_conversation !== w.head.conv)
					report_mismatch("head_conversation", head_conversation, w.head.conv);
				if (head_message_ref !== w.head.msg)
					report_mismatch("head_message_ref", head_message_ref, w.head.msg);
				if (head_time_ms !== w.head.time_ms)
					report_mismatch("head_time_ms", head_time_ms, w.head.time_ms);
				if (head_expiry_ms !== w.head.deadline)
					report_mismatch("head_expiry_ms", head_expiry_ms, w.head.deadline);
			end
		end
	end

	task automatic drain();
		while (pending_events.size() > 0 || in_valid || expected_outcomes.size() > 0)
			@(negedge clk);
		repeat (QueueDepth + 6) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW: window_ms = val;
			REG_TTL: ttl_ms = val;
			default: banner_code = val[1:0];
		endcase
	endtask

	function automatic event_t make_event(logic [1:0] act, logic [3:0] k, logic [1:0] t,
			logic [31:0] n, logic [7:0] c, logic [31:0] now, logic [2:0] s);
		event_t ev;
		ev = '{act, k, t, n, c, 16'($urandom), now, s};
		return ev;
	endfunction

	logic [31:0] clock_ms;

	task automatic random_phase(int count);
		int r;
		event_t ev;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			clock_ms += $urandom_range(0, 10) == 0 ? $urandom : $urandom_range(0, 1500);
			// Small key space so that pushes find matches and coalesce.
			ev = make_event(ACT_PUSH, $urandom_range(0, 2), $urandom_range(0, 3),
				$urandom_range(0, 3) == 0 ? $urandom : {30'd0, 2'($urandom)},
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)),
				clock_ms, $urandom);
			if (r >= 55) ev.action = ACT_TICK;
			if (r >= 72) ev.action = ACT_POP;
			if (r >= 82) ev.action = ACT_DISMISS;
			if ($urandom_range(0, 15) == 0) ev.kind = $urandom;
			pending_events.push_back(ev);
		end
		drain();
	endtask

	initial begin
		window_ms = 2000;
		ttl_ms = 5000;
		banner_code = 1;
		held = 0;
		clock_ms = 32'hFFFF_F000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		pending_events.push_back(make_event(ACT_POP, 0, 0, 0, 0, 0, 0));
		pending_events.push_back(make_event(ACT_DISMISS, 0, 0, 0, 0, 0, 7));
		pending_events.push_back(make_event(ACT_TICK, 0, 0, 0, 0, 0, 0));
		pending_events.push_back(make_event(ACT_PUSH, 15, 3, 32'hFFFF_FFFF, 8'hFF, 100, 0));
		pending_events.push_back(make_event(ACT_PUSH, 15, 3, 32'hFFFF_FFFF, 8'hFF, 2100, 0));
		pending_events.push_back(make_event(ACT_PUSH, 15, 3, 32'hFFFF_FFFF, 8'hFF, 50, 0));
		pending_events.push_back(make_event(ACT_PUSH, 15, 3, 32'hFFFF_FFFF, 8'hFF, 4200, 0));
		pending_events.push_back(make_event(ACT_PUSH, 0, 1, 0, 0, 32'hFFFF_EC78, 0));
		for (int i = 1; i < 8; i++)
			pending_events.push_back(make_event(ACT_PUSH, i, 1, i, i, 32'h100 * i, 0));
		pending_events.push_back(make_event(ACT_DISMISS, 0, 0, 0, 0, 0, 7));
		pending_events.push_back(make_event(ACT_DISMISS, 0, 0, 0, 0, 0, 2));
		pending_events.push_back(make_event(ACT_TICK, 0, 0, 0, 0, 32'h600 + 5000, 0));
		pending_events.push_back(make_event(ACT_TICK, 0, 0, 0, 0, 32'h7000_0000, 0));
		pending_events.push_back(make_event(ACT_POP, 0, 0, 0, 0, 0, 0));
		drain();

		random_phase(250);
		write_reg(REG_WINDOW, 31'h7FFF_FFFF);
		write_reg(REG_TTL, 31'h7FFF_FFFF);
		write_reg(REG_TIER, 2'd3);
		random_phase(200);
		write_reg(REG_WINDOW, 31'd0);
		write_reg(REG_TTL, 31'd0);
		write_reg(REG_TIER, 2'd0);
		random_phase(200);
		write_reg(REG_WINDOW, 31'd700);
		write_reg(REG_TTL, 31'd1200);
		write_reg(REG_TIER, 2'd2);
		random_phase(250);

		if (errors == 0)
			$display("coalescing_expiring_event_queue regression: pass");
		else
			$display("coalescing_expiring_event_queue regression: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("coalescing_expiring_event_queue regression: fail");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/ceq_pkg.sv
rtl/ceq_cell.sv
rtl/coalescing_expiring_event_queue.sv
tb/tb_coalescing_expiring_event_queue.sv
